// ----- rtl/core/lti_pkg.sv -----
// lti_pkg: sizes, codes and the controller state type of the table interpolator
// shared by every file under rtl/core; depends on nothing
package lti_pkg;

   localparam int TABLE_ROWS = 64;
   localparam int SPECIES    = 8;

   localparam int ROW_W  = $clog2(TABLE_ROWS);
   localparam int SP_W   = (SPECIES > 1) ? $clog2(SPECIES) : 1;
   localparam int CNT_W  = $clog2(SPECIES + 1);
   localparam int ADDR_W = ROW_W + SP_W;

   // fixed field widths
   localparam int LP_W    = 24;
   localparam int STEP_W  = 23;
   localparam int LR_W    = 6;
   localparam int NSP_W   = 4;
   localparam int VAL_W   = 16;
   localparam int SUM_W   = 20;
   localparam int OUT_SP_W = 3;
   localparam int CSR_W   = 24;
   localparam int IDX_W   = 2;

   // datapath widths
   localparam int D_W    = LP_W + 1;
   localparam int FNUM_W = LP_W + 2;
   localparam int PROD_W = VAL_W + 1 + FNUM_W;
   localparam int DIV_W  = PROD_W;
   localparam int DVS_W  = STEP_W;

   localparam logic [IDX_W-1:0] REG_LOG_P_MIN      = 2'd0;
   localparam logic [IDX_W-1:0] REG_LOG_P_STEP     = 2'd1;
   localparam logic [IDX_W-1:0] REG_LAST_ROW       = 2'd2;
   localparam logic [IDX_W-1:0] REG_SPECIES_IN_USE = 2'd3;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_IP,
      ST_MUL_IP,
      ST_RD0,
      ST_RD1,
      ST_MUL,
      ST_VSTART,
      ST_VWAIT,
      ST_NRD,
      ST_NSTART,
      ST_NWAIT
   } state_type;

endpackage

// ----- rtl/core/lti_table.sv -----
// lti_table: single-port fraction table, one word per row and species
// registered read data; uses lti_pkg
module lti_table (
   input  logic                       clock,
   input  logic                       we,
   input  logic [lti_pkg::ADDR_W-1:0] addr,
   input  logic [lti_pkg::VAL_W-1:0]  wdata,
   output logic [lti_pkg::VAL_W-1:0]  rdata
);
   import lti_pkg::*;

   logic [VAL_W-1:0] mem [TABLE_ROWS*SPECIES];
   logic [VAL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/lti_div.sv -----
// lti_div: restoring unsigned divider, one quotient bit per cycle
// used for row index, interpolation and normalization; uses lti_pkg
module lti_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [lti_pkg::DIV_W-1:0] dividend,
   input  logic [lti_pkg::DVS_W-1:0] divisor,
   output logic                      done,
   output logic [lti_pkg::DIV_W-1:0] quotient,
   output logic                      rem_nz
);
   import lti_pkg::*;

   localparam int C_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [C_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = C_W'(DIV_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == C_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign rem_nz   = |rem_ff;

endmodule

// ----- rtl/core/log_table_interp_normalize.sv -----
// log_table_interp_normalize: top level, controller and datapath
// uses lti_pkg, lti_table, lti_div
//
//  channel   ports                                  handshake
//  request   req_command .. req_log_pressure        start, busy (taken when start & !busy)
//  response  rsp_species_index .. rsp_status        rsp_strobe, one cycle, no back-pressure
//  csr       csr_index, csr_wdata                   csr_we, taken at once
//
// a load beat leaves busy low
// a query holds busy through the row-index division, then through interpolation of
// every species in use and then normalization of every species in use; each
// quotient comes from the shared 43-step divider
// a negative offset skips the row division, a zero sum skips the normalizing division
// reset is synchronous; control and csr registers reset, data registers and table do not
// results cannot be stalled, each is flagged by rsp_strobe for exactly one cycle
module log_table_interp_normalize (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_command,
   input  logic [5:0]                  req_table_row,
   input  logic [2:0]                  req_table_species,
   input  logic [lti_pkg::VAL_W-1:0]   req_table_value,
   input  logic signed [lti_pkg::LP_W-1:0] req_log_pressure,
   output logic                        rsp_strobe,
   output logic [lti_pkg::OUT_SP_W-1:0] rsp_species_index,
   output logic [lti_pkg::VAL_W-1:0]   rsp_mass_fraction,
   output logic                        rsp_last,
   output logic                        rsp_status,
   input  logic                        csr_we,
   input  logic [lti_pkg::IDX_W-1:0]   csr_index,
   input  logic [lti_pkg::CSR_W-1:0]   csr_wdata
);
   import lti_pkg::*;

   state_type state_ff, state_in;

   logic signed [LP_W-1:0] min_ff;
   logic [STEP_W-1:0]      step_ff;
   logic [LR_W-1:0]        lr_ff;
   logic [NSP_W-1:0]       nsp_ff;

   logic [STEP_W-1:0] step_eff;
   logic [LR_W-1:0]   lr_eff;
   logic [CNT_W-1:0]  nsp_eff;

   logic signed [D_W-1:0]    d_ff, d_now;
   logic [ROW_W-1:0]         ip_ff;
   logic signed [FNUM_W-1:0] fnum_ff;
   logic [VAL_W-1:0]         f0_ff;
   logic [DIV_W-1:0]         pmag_ff;
   logic                     pneg_ff;
   logic [CNT_W-1:0]         sp_ff;
   logic [SUM_W-1:0]         sum_ff;
   logic [VAL_W-1:0]         vbuf_ff;
   logic [VAL_W-1:0]         ibuf [SPECIES];

   logic                rsp_strobe_ff;
   logic [OUT_SP_W-1:0] rsp_sp_ff;
   logic [VAL_W-1:0]    rsp_mf_ff;
   logic                rsp_last_ff;
   logic                rsp_status_ff;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_addr;
   logic [VAL_W-1:0]   mem_rdata;
   logic               div_start;
   logic [DIV_W-1:0]   div_dividend;
   logic [DVS_W-1:0]   div_divisor;
   logic               div_done;
   logic [DIV_W-1:0]   div_q;
   logic               div_rnz;

   logic               accept;
   logic               is_last;
   logic [ROW_W-1:0]   ip_clamp;
   logic [LR_W+STEP_W-1:0] ipstep;
   logic signed [FNUM_W+4:0] fnum_wide;
   logic signed [VAL_W:0]    fdiff;
   logic signed [PROD_W-1:0] prod;
   logic [DIV_W:0]     mag_neg;
   logic [VAL_W:0]     vpos_sum;
   logic [VAL_W-1:0]   v_new;
   logic [VAL_W-1:0]   mf_new;

   lti_table u_table (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (req_table_value),
      .rdata (mem_rdata)
   );

   lti_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q),
      .rem_nz   (div_rnz)
   );

   // sanitized configuration
   always_comb begin
      step_eff = (step_ff == '0) ? STEP_W'(1) : step_ff;
      lr_eff   = (lr_ff == '0) ? LR_W'(1) : lr_ff;
      if ({1'b0, lr_eff} > (LR_W+1)'(TABLE_ROWS - 1)) begin
         lr_eff = LR_W'(TABLE_ROWS - 1);
      end
      if (nsp_ff == '0) begin
         nsp_eff = CNT_W'(1);
      end else if ({1'b0, nsp_ff} > (NSP_W+1)'(SPECIES)) begin
         nsp_eff = CNT_W'(SPECIES);
      end else begin
         nsp_eff = CNT_W'(nsp_ff);
      end
   end

   always_comb begin
      accept  = start && (state_ff == ST_IDLE) && !reset;
      d_now   = D_W'(req_log_pressure) - D_W'(min_ff);
      is_last = ((sp_ff + 1'b1) == nsp_eff);
      // row index clamp to 0 .. last_row-1
      if (div_q > DIV_W'(lr_eff - 1'b1)) begin
         ip_clamp = ROW_W'(lr_eff - 1'b1);
      end else begin
         ip_clamp = div_q[ROW_W-1:0];
      end
      ipstep    = ip_ff * step_eff;
      fnum_wide = (FNUM_W+5)'(d_ff) - $signed({1'b0, (FNUM_W+4)'(ipstep)});
      fdiff     = $signed({1'b0, mem_rdata}) - $signed({1'b0, f0_ff});
      prod      = PROD_W'(fdiff) * PROD_W'(fnum_ff);
      // floor quotient added to the base word, then clipped to 0 .. 16'hFFFF
      mag_neg   = {1'b0, div_q} + (DIV_W+1)'(div_rnz);
      vpos_sum  = {1'b0, div_q[VAL_W-1:0]} + {1'b0, f0_ff};
      if (pneg_ff) begin
         v_new = (mag_neg > (DIV_W+1)'(f0_ff)) ? '0 : f0_ff - mag_neg[VAL_W-1:0];
      end else if (div_q > DIV_W'({VAL_W{1'b1}}) || vpos_sum[VAL_W]) begin
         v_new = '1;
      end else begin
         v_new = vpos_sum[VAL_W-1:0];
      end
      mf_new = (div_q > DIV_W'({VAL_W{1'b1}})) ? '1 : div_q[VAL_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_command == CMD_QUERY) begin
               state_in = d_now[D_W-1] ? ST_MUL_IP : ST_DIV_IP;
            end
         end
         ST_DIV_IP: if (div_done) state_in = ST_MUL_IP;
         ST_MUL_IP: state_in = ST_RD0;
         ST_RD0:    state_in = ST_RD1;
         ST_RD1:    state_in = ST_MUL;
         ST_MUL:    state_in = ST_VSTART;
         ST_VSTART: state_in = ST_VWAIT;
         ST_VWAIT: begin
            if (div_done) begin
               state_in = is_last ? ST_NRD : ST_RD0;
            end
         end
         ST_NRD:    state_in = ST_NSTART;
         ST_NSTART: begin
            if (sum_ff == '0) begin
               state_in = is_last ? ST_IDLE : ST_NRD;
            end else begin
               state_in = ST_NWAIT;
            end
         end
         ST_NWAIT: begin
            if (div_done) begin
               state_in = is_last ? ST_IDLE : ST_NRD;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      busy         = (state_ff != ST_IDLE);
      mem_we       = 1'b0;
      mem_addr     = {ip_ff, sp_ff[SP_W-1:0]};
      div_start    = 1'b0;
      div_dividend = DIV_W'(d_now);
      div_divisor  = step_eff;
      unique case (state_ff)
         ST_IDLE: begin
            mem_addr = {req_table_row[ROW_W-1:0], req_table_species[SP_W-1:0]};
            if (accept && req_command == CMD_LOAD
                && 32'(req_table_row) < TABLE_ROWS
                && 32'(req_table_species) < SPECIES) begin
               mem_we = 1'b1;
            end
            if (accept && req_command == CMD_QUERY && !d_now[D_W-1]) begin
               div_start = 1'b1;
            end
         end
         ST_RD1: mem_addr = {ip_ff + 1'b1, sp_ff[SP_W-1:0]};
         ST_VSTART: begin
            div_start    = 1'b1;
            div_dividend = pmag_ff;
         end
         ST_NSTART: begin
            div_start    = (sum_ff != '0);
            div_dividend = DIV_W'({vbuf_ff, {VAL_W{1'b0}}}) + DIV_W'(sum_ff >> 1);
            div_divisor  = DVS_W'(sum_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         min_ff        <= '0;
         step_ff       <= STEP_W'(65536);
         lr_ff         <= LR_W'(63);
         nsp_ff        <= NSP_W'(8);
         sum_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= ((state_ff == ST_NSTART) && (sum_ff == '0))
                          || ((state_ff == ST_NWAIT) && div_done);
         if (csr_we) begin
            case (csr_index)
               REG_LOG_P_MIN:      min_ff  <= csr_wdata[LP_W-1:0];
               REG_LOG_P_STEP:     step_ff <= csr_wdata[STEP_W-1:0];
               REG_LAST_ROW:       lr_ff   <= csr_wdata[LR_W-1:0];
               REG_SPECIES_IN_USE: nsp_ff  <= csr_wdata[NSP_W-1:0];
               default: begin
               end
            endcase
         end
         if (state_ff == ST_MUL_IP) begin
            sum_ff <= '0;
         end else if (state_ff == ST_VWAIT && div_done) begin
            sum_ff <= sum_ff + SUM_W'(v_new);
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            d_ff  <= d_now;
            ip_ff <= '0;
         end
         ST_DIV_IP: if (div_done) ip_ff <= ip_clamp;
         ST_MUL_IP: begin
            fnum_ff <= fnum_wide[FNUM_W-1:0];
            sp_ff   <= '0;
         end
         ST_RD1: f0_ff <= mem_rdata;
         ST_MUL: begin
            pneg_ff <= prod[PROD_W-1];
            pmag_ff <= prod[PROD_W-1] ? DIV_W'(-prod) : DIV_W'(prod);
         end
         ST_VWAIT: begin
            if (div_done) begin
               ibuf[sp_ff[SP_W-1:0]] <= v_new;
               sp_ff <= is_last ? '0 : sp_ff + 1'b1;
            end
         end
         ST_NRD: vbuf_ff <= ibuf[sp_ff[SP_W-1:0]];
         ST_NSTART: begin
            if (sum_ff == '0) begin
               rsp_sp_ff     <= sp_ff[OUT_SP_W-1:0];
               rsp_mf_ff     <= '0;
               rsp_last_ff   <= is_last;
               rsp_status_ff <= 1'b1;
               sp_ff         <= sp_ff + 1'b1;
            end
         end
         ST_NWAIT: begin
            if (div_done) begin
               rsp_sp_ff     <= sp_ff[OUT_SP_W-1:0];
               rsp_mf_ff     <= mf_new;
               rsp_last_ff   <= is_last;
               rsp_status_ff <= 1'b0;
               sp_ff         <= sp_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_species_index = rsp_sp_ff;
   assign rsp_mass_fraction = rsp_mf_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

// ----- rtl/core/lti_checker.sv -----
// lti_checker: port-level assertions for log_table_interp_normalize
// bound to the top level below; uses lti_pkg
module lti_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          req_command,
   input logic                          rsp_strobe,
   input logic [lti_pkg::VAL_W-1:0]     rsp_mass_fraction,
   input logic                          rsp_last,
   input logic                          rsp_status
);
   import lti_pkg::*;

   // a query beat always keeps the block occupied
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_command == CMD_QUERY |=> busy)
      else $error("query beat did not raise busy");

   // a load beat never produces a result
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_command == CMD_LOAD |=> !busy && !rsp_strobe)
      else $error("load beat disturbed busy or result strobe");

   // zero-sum results carry a zero fraction
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status |-> rsp_mass_fraction == '0)
      else $error("error result with nonzero fraction");

   // the final result of a query is never followed at once by another
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe)
      else $error("result directly after final result");

endmodule

bind log_table_interp_normalize lti_checker u_lti_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_command       (req_command),
   .rsp_strobe        (rsp_strobe),
   .rsp_mass_fraction (rsp_mass_fraction),
   .rsp_last          (rsp_last),
   .rsp_status        (rsp_status)
);
